// File: sv/qmn_pkg.sv
// Shared constants and a helper function for the normalized quaternion product pipeline.
// No dependencies.
package qmn_pkg;

	localparam int unsigned CW_DEFAULT = 32;

	localparam int unsigned IN_TGT     = 29;
	localparam int unsigned IN_MAG_W   = 30;
	localparam int unsigned PR_TGT     = 30;
	localparam int unsigned PR_MAG_W   = 31;
	localparam int unsigned PR_SIGN_W  = 63;
	localparam int unsigned TERM_W     = 62;
	localparam int unsigned SQ_W       = 62;
	localparam int unsigned SSUM_W     = 64;
	localparam int unsigned ROOT_W     = 32;

	function automatic logic [2:0] lead8(input logic [7:0] v);
		logic [2:0] p;
		p = '0;
		for (int b = 0; b < 8; b++) begin
			if (v[b])
				p = 3'(b);
		end
		return p;
	endfunction

endpackage

// File: sv/qmn_norm.sv
// Block scaling of four signed components to a fixed leading-one position.
// Four pipeline stages. Depends on qmn_pkg.
module qmn_norm #(
	parameter int unsigned IN_W  = 32,
	parameter int unsigned OUT_W = 30,
	parameter int unsigned TGT   = 29
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    ce,
	input  logic                    in_valid,
	input  logic                    in_flag,
	input  logic signed [IN_W-1:0]  comp [4],
	output logic                    out_valid,
	output logic                    out_zero,
	output logic [3:0]              out_neg,
	output logic [OUT_W-1:0]        out_mag [4],
	output logic signed [OUT_W:0]   out_val [4]
);

	localparam int unsigned NCH   = (IN_W + 7) / 8;
	localparam int unsigned PAD_W = NCH * 8;
	localparam int unsigned LW    = $clog2(PAD_W);
	localparam int unsigned EXT_W = PAD_W + TGT;

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	logic               flag_s1, flag_s2, flag_s3, zero_s4;
	logic [3:0]         neg_s1, neg_s2, neg_s3, neg_s4;
	logic [PAD_W-1:0]   mag_s1 [4];
	logic [PAD_W-1:0]   mag_s2 [4];
	logic [PAD_W-1:0]   mag_s3 [4];
	logic [PAD_W-1:0]   or_s1;
	logic [NCH-1:0]     nz_s2;
	logic [2:0]         pos_s2 [NCH];
	logic [LW-1:0]      lead_s3;
	logic               zero_s3;
	logic [OUT_W-1:0]   mag_s4 [4];
	logic signed [OUT_W:0] val_s4 [4];

	logic [PAD_W-1:0]   mag_c [4];
	logic [PAD_W-1:0]   or_c;
	logic [LW-1:0]      lead_c;
	logic               zero_c;
	logic [OUT_W-1:0]   sh_c [4];
	logic [EXT_W-1:0]   ext_c [4];

	always_comb begin
		or_c = '0;
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = comp[i][IN_W-1] ? PAD_W'($unsigned(IN_W'(-comp[i])))
				: PAD_W'($unsigned(comp[i]));
			or_c = or_c | mag_c[i];
		end
	end

	always_comb begin
		lead_c = '0;
		zero_c = 1'b1;
		for (int c = 0; c < NCH; c++) begin
			if (nz_s2[c]) begin
				lead_c = LW'(c * 8 + int'(pos_s2[c]));
				zero_c = 1'b0;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ext_c[i] = {mag_s3[i], {TGT{1'b0}}} >> lead_s3;
			sh_c[i] = ext_c[i][OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			flag_s1 <= in_flag;
			or_s1 <= or_c;
			for (int i = 0; i < 4; i++) begin
				neg_s1[i] <= comp[i][IN_W-1];
				mag_s1[i] <= mag_c[i];
			end
			flag_s2 <= flag_s1;
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			for (int c = 0; c < NCH; c++) begin
				nz_s2[c] <= |or_s1[c*8 +: 8];
				pos_s2[c] <= qmn_pkg::lead8(or_s1[c*8 +: 8]);
			end
			flag_s3 <= flag_s2;
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			lead_s3 <= lead_c;
			zero_s3 <= zero_c;
			zero_s4 <= flag_s3 | zero_s3;
			neg_s4 <= neg_s3;
			for (int i = 0; i < 4; i++) begin
				mag_s4[i] <= sh_c[i];
				val_s4[i] <= neg_s3[i] ? -$signed({1'b0, sh_c[i]}) : $signed({1'b0, sh_c[i]});
			end
		end
	end

	assign out_valid = valid_s4;
	assign out_zero  = zero_s4;
	assign out_neg   = neg_s4;
	assign out_mag   = mag_s4;
	assign out_val   = val_s4;

endmodule

// File: sv/qmn_div.sv
// Digit-recurrence divider lanes: round(mag * 2^(CW-2) / root), sign applied.
// CW digit stages plus an output register. Depends on qmn_pkg.
module qmn_div #(
	parameter int unsigned CW = qmn_pkg::CW_DEFAULT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           ce,
	input  logic                           in_valid,
	input  logic                           in_zero,
	input  logic [3:0]                     in_neg,
	input  logic [qmn_pkg::ROOT_W-1:0]     in_root,
	input  logic [qmn_pkg::PR_MAG_W-1:0]   in_mag [4],
	output logic                           out_valid,
	output logic                           out_zero,
	output logic [CW-1:0]                  out_prod [4]
);

	localparam int unsigned RW = qmn_pkg::ROOT_W;

	logic              valid_s [0:CW];
	logic              zero_s  [0:CW];
	logic [3:0]        neg_s   [0:CW];
	logic [RW-1:0]     root_s  [0:CW];
	logic [RW-1:0]     rem_s   [0:CW][4];
	logic [CW-1:0]     q_s     [0:CW][4];

	logic              valid_q;
	logic              zero_q;
	logic [CW-1:0]     prod_q [4];
	logic [CW-1:0]     rnd_c  [4];

	assign valid_s[0] = in_valid;
	assign zero_s[0]  = in_zero;
	assign neg_s[0]   = in_neg;
	assign root_s[0]  = in_root;
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			rem_s[0][i] = RW'(in_mag[i]);
			q_s[0][i]   = '0;
		end
	end

	for (genvar k = 0; k < CW; k++) begin : g_dig
		logic [RW:0]   t_c   [4];
		logic          ge_c  [4];

		always_comb begin
			for (int i = 0; i < 4; i++) begin
				if (k == 0)
					t_c[i] = (RW+1)'(rem_s[k][i]);
				else
					t_c[i] = {rem_s[k][i], 1'b0};
				ge_c[i] = t_c[i] >= (RW+1)'(root_s[k]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[k+1] <= 1'b0;
			else if (ce)
				valid_s[k+1] <= valid_s[k];
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				zero_s[k+1] <= zero_s[k];
				neg_s[k+1]  <= neg_s[k];
				root_s[k+1] <= root_s[k];
				for (int i = 0; i < 4; i++) begin
					rem_s[k+1][i] <= ge_c[i] ? RW'(t_c[i] - (RW+1)'(root_s[k])) : RW'(t_c[i]);
					q_s[k+1][i]   <= {q_s[k][i][CW-2:0], ge_c[i]};
				end
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			rnd_c[i] = CW'(({1'b0, q_s[CW][i]} + (CW+1)'(1)) >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (ce)
			valid_q <= valid_s[CW];
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_q <= zero_s[CW];
			for (int i = 0; i < 4; i++) begin
				if (zero_s[CW])
					prod_q[i] <= '0;
				else if (neg_s[CW][i])
					prod_q[i] <= -rnd_c[i];
				else
					prod_q[i] <= rnd_c[i];
			end
		end
	end

	assign out_valid = valid_q;
	assign out_zero  = zero_q;
	assign out_prod  = prod_q;

endmodule

// File: sv/quaternion_multiply_normalize.sv
// Normalized Hamilton quaternion product, fully pipelined top level.
// Depends on qmn_pkg, qmn_norm and qmn_div.
//
// Takes one quaternion pair per cycle and returns left * right scaled to unit length,
// one result per cycle while the result side does not stall. The steps are block
// scaling of both inputs, product and sum, block scaling of the product, squared
// magnitude, the pipelined integer square root and the per-component divider lanes.
// A zero input quaternion gives zero components with zero_magnitude set. Back-pressure
// on the result side holds the whole pipeline.
module quaternion_multiply_normalize #(
	parameter  int unsigned CW         = qmn_pkg::CW_DEFAULT,
	localparam int unsigned OUT_DATA_W = ((4 * CW + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// left_w, left_x, left_y, left_z, right_w, right_x, right_y, right_z
	input  logic [8*CW-1:0]       s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// prod_w, prod_x, prod_y, prod_z, zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	// zero_magnitude
	output logic [0:0]            m_tuser
);

	localparam int unsigned AW  = qmn_pkg::IN_MAG_W;
	localparam int unsigned PW  = qmn_pkg::PR_MAG_W;
	localparam int unsigned SW  = qmn_pkg::SSUM_W;
	localparam int unsigned RW  = qmn_pkg::ROOT_W;

	logic ce;

	logic signed [CW-1:0] comp_a [4];
	logic signed [CW-1:0] comp_b [4];
	logic                 va, vb, za, zb;
	logic [3:0]           nga, ngb;
	logic [AW-1:0]        ma [4];
	logic [AW-1:0]        mb [4];
	logic signed [AW:0]   val_a [4];
	logic signed [AW:0]   val_b [4];

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic                 zero_s1, zero_s2, zero_s3, zero_s4;
	logic signed [qmn_pkg::TERM_W-1:0]    mul_s1 [16];
	logic signed [qmn_pkg::PR_SIGN_W-1:0] sum_s2 [4];

	logic                 vp, zp;
	logic [3:0]           ngp, neg_s3, neg_s4;
	logic [PW-1:0]        mp [4];
	logic signed [PW:0]   valp [4];
	logic [PW-1:0]        mag_s3 [4];
	logic [PW-1:0]        mag_s4 [4];
	logic [qmn_pkg::SQ_W-1:0] sq_s3 [4];
	logic [SW-1:0]        ssum_s4;

	logic                 rv_s   [0:RW];
	logic                 rz_s   [0:RW];
	logic [3:0]           rn_s   [0:RW];
	logic [PW-1:0]        rm_s   [0:RW][4];
	logic [SW-1:0]        rem_s  [0:RW];
	logic [RW-1:0]        root_s [0:RW];

	logic [CW-1:0]        prod [4];
	logic                 zero_out;

	assign ce       = !m_tvalid || m_tready;
	assign s_tready = ce;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			comp_a[i] = s_tdata[i*CW +: CW];
			comp_b[i] = s_tdata[(4+i)*CW +: CW];
		end
	end

	qmn_norm #(.IN_W(CW), .OUT_W(AW), .TGT(qmn_pkg::IN_TGT)) u_norm_a (
		.clk, .arst_n, .ce,
		.in_valid(s_tvalid && s_tready), .in_flag(1'b0), .comp(comp_a),
		.out_valid(va), .out_zero(za), .out_neg(nga), .out_mag(ma), .out_val(val_a)
	);

	qmn_norm #(.IN_W(CW), .OUT_W(AW), .TGT(qmn_pkg::IN_TGT)) u_norm_b (
		.clk, .arst_n, .ce,
		.in_valid(s_tvalid && s_tready), .in_flag(1'b0), .comp(comp_b),
		.out_valid(vb), .out_zero(zb), .out_neg(ngb), .out_mag(mb), .out_val(val_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (ce) begin
			valid_s1 <= va && vb;
			valid_s2 <= valid_s1;
			valid_s3 <= vp;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_s1 <= za | zb;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++)
					mul_s1[i*4+j] <= val_a[i] * val_b[j];
			zero_s2 <= zero_s1;
			sum_s2[0] <= qmn_pkg::PR_SIGN_W'(mul_s1[0])  - qmn_pkg::PR_SIGN_W'(mul_s1[5])
				- qmn_pkg::PR_SIGN_W'(mul_s1[10]) - qmn_pkg::PR_SIGN_W'(mul_s1[15]);
			sum_s2[1] <= qmn_pkg::PR_SIGN_W'(mul_s1[1])  + qmn_pkg::PR_SIGN_W'(mul_s1[4])
				+ qmn_pkg::PR_SIGN_W'(mul_s1[11]) - qmn_pkg::PR_SIGN_W'(mul_s1[14]);
			sum_s2[2] <= qmn_pkg::PR_SIGN_W'(mul_s1[2])  - qmn_pkg::PR_SIGN_W'(mul_s1[7])
				+ qmn_pkg::PR_SIGN_W'(mul_s1[8])  + qmn_pkg::PR_SIGN_W'(mul_s1[13]);
			sum_s2[3] <= qmn_pkg::PR_SIGN_W'(mul_s1[3])  + qmn_pkg::PR_SIGN_W'(mul_s1[6])
				- qmn_pkg::PR_SIGN_W'(mul_s1[9])  + qmn_pkg::PR_SIGN_W'(mul_s1[12]);
		end
	end

	qmn_norm #(.IN_W(qmn_pkg::PR_SIGN_W), .OUT_W(PW), .TGT(qmn_pkg::PR_TGT)) u_norm_p (
		.clk, .arst_n, .ce,
		.in_valid(valid_s2), .in_flag(zero_s2), .comp(sum_s2),
		.out_valid(vp), .out_zero(zp), .out_neg(ngp), .out_mag(mp), .out_val(valp)
	);

	always_ff @(posedge clk) begin
		if (ce) begin
			zero_s3 <= zp | (valp[0] == '0 && valp[1] == '0 && valp[2] == '0 && valp[3] == '0);
			neg_s3 <= ngp;
			mag_s3 <= mp;
			for (int i = 0; i < 4; i++)
				sq_s3[i] <= mp[i] * mp[i];
			zero_s4 <= zero_s3;
			neg_s4 <= neg_s3;
			mag_s4 <= mag_s3;
			ssum_s4 <= SW'(sq_s3[0]) + SW'(sq_s3[1]) + SW'(sq_s3[2]) + SW'(sq_s3[3]);
		end
	end

	assign rv_s[0]   = valid_s4;
	assign rz_s[0]   = zero_s4;
	assign rn_s[0]   = neg_s4;
	assign rm_s[0]   = mag_s4;
	assign rem_s[0]  = ssum_s4;
	assign root_s[0] = '0;

	for (genvar k = 0; k < RW; k++) begin : g_root
		localparam int unsigned J = RW - 1 - k;
		logic [SW:0] trial_c;
		logic        ge_c;

		always_comb begin
			trial_c = ((SW+1)'(root_s[k]) << (J + 1)) | ((SW+1)'(1) << (2 * J));
			ge_c = (SW+1)'(rem_s[k]) >= trial_c;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rv_s[k+1] <= 1'b0;
			else if (ce)
				rv_s[k+1] <= rv_s[k];
		end

		always_ff @(posedge clk) begin
			if (ce) begin
				rz_s[k+1] <= rz_s[k];
				rn_s[k+1] <= rn_s[k];
				rm_s[k+1] <= rm_s[k];
				rem_s[k+1] <= ge_c ? SW'((SW+1)'(rem_s[k]) - trial_c) : rem_s[k];
				root_s[k+1] <= ge_c ? (root_s[k] | (RW'(1) << J)) : root_s[k];
			end
		end
	end

	qmn_div #(.CW(CW)) u_div (
		.clk, .arst_n, .ce,
		.in_valid(rv_s[RW]), .in_zero(rz_s[RW]), .in_neg(rn_s[RW]),
		.in_root(root_s[RW]), .in_mag(rm_s[RW]),
		.out_valid(m_tvalid), .out_zero(zero_out), .out_prod(prod)
	);

	always_comb begin
		m_tdata = '0;
		for (int i = 0; i < 4; i++)
			m_tdata[i*CW +: CW] = prod[i];
	end

	assign m_tuser[0] = zero_out;

endmodule

// File: sv/qmn_check.sv
// Port-level checks for the normalized quaternion product, bound to the top level.
// Depends on qmn_pkg and quaternion_multiply_normalize.
module qmn_check #(
	parameter int unsigned CW = qmn_pkg::CW_DEFAULT
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_tvalid,
	input logic                              s_tready,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [((4*CW+7)/8)*8-1:0]         m_tdata,
	input logic [0:0]                        m_tuser
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result request changed while stalled");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("zero magnitude with nonzero components");

	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled with free output");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input request taken during output stall");

endmodule

bind quaternion_multiply_normalize qmn_check #(.CW(CW)) u_qmn_check (.*);
